[src/vkdt_pkg.sv]
// ----------------------------------------------------------------------------
// vkdt_pkg
// shared types and constants of the vertex key find-or-insert table
// ----------------------------------------------------------------------------
`default_nettype none
package vkdt_pkg;
   localparam int unsigned TableDepthDefault = 1024;
   localparam int unsigned KeyWords          = 10;
   localparam int unsigned KeyWidth          = 32 * KeyWords;
   localparam int unsigned IndexWidth        = 10;

   typedef logic [1:0] outcome_type;
   localparam outcome_type OutcomeFound    = 2'd0;
   localparam outcome_type OutcomeInserted = 2'd1;
   localparam outcome_type OutcomeFull     = 2'd2;

   typedef struct packed {
      logic        new_model;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] pos_w;
      logic [31:0] tex_u;
      logic [31:0] tex_v;
      logic [31:0] tex_s;
      logic [31:0] norm_x;
      logic [31:0] norm_y;
      logic [31:0] norm_z;
   } req_type;

   typedef struct packed {
      logic [IndexWidth-1:0] entry_index;
      outcome_type           outcome;
   } rsp_type;

   typedef enum logic [1:0] {
      StIdle,
      StRead,
      StCompare,
      StRespond
   } state_type;

   function automatic logic is_nan(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   function automatic logic comp_equal(input logic [31:0] a, input logic [31:0] b);
      logic r;
      if (is_nan(a) || is_nan(b)) r = 1'b0;
      else if (((a | b) & 32'h7FFF_FFFF) == 32'd0) r = 1'b1;
      else r = (a == b);
      return r;
   endfunction
endpackage
`default_nettype wire

[src/vkdt_req_if.sv]
// ----------------------------------------------------------------------------
// vkdt_req_if
// request channel: valid, ready and one vertex key
// ----------------------------------------------------------------------------
`default_nettype none
interface vkdt_req_if;
   import vkdt_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/vkdt_rsp_if.sv]
// ----------------------------------------------------------------------------
// vkdt_rsp_if
// response channel: valid, ready and index with outcome
// ----------------------------------------------------------------------------
`default_nettype none
interface vkdt_rsp_if;
   import vkdt_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/vertex_key_dedup_table_core.sv]
// ----------------------------------------------------------------------------
// vertex_key_dedup_table_core
// find-or-insert table of vertex keys with linear search
// ----------------------------------------------------------------------------
// usage: a request carries a ten-component vertex key and a new_model flag.
// the key is compared against stored entries in insertion order, one entry
// at a time (ram read, then compare). a match returns its index with
// outcome found; otherwise the key is appended (outcome inserted) or, when
// the table holds TABLE_DEPTH entries, outcome full with index zero.
// the search is serial, as there is a single ram read port and a shared
// comparator. one request is handled at a time; req_ready is low from
// acceptance until the response is taken, and the next request can be
// taken in the cycle after that.
// reset empties the table (entry count zero); the ram needs no clearing.
// a stalled receiver holds the response register and the block waits.
// new_model empties the table before its own lookup.
// ----------------------------------------------------------------------------
`default_nettype none
module vertex_key_dedup_table_core #(
   parameter int unsigned TABLE_DEPTH = vkdt_pkg::TableDepthDefault
) (
   input wire logic   clock,
   input wire logic   reset,
   vkdt_req_if.sink   req,
   vkdt_rsp_if.source rsp
);
   import vkdt_pkg::*;
   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [KeyWidth-1:0] key_ff, key_in;
   rsp_type rsp_ff, rsp_in;
   logic [KeyWidth-1:0] rd_data;
   logic wr_en;
   logic match;

   vkdt_key_ram #(.DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (key_ff),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      match = 1'b1;
      for (int k = 0; k < KeyWords; k++) begin
         if (!comp_equal(rd_data[32*k +: 32], key_ff[32*k +: 32])) match = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StIdle:    if (req.valid) state_in = StRead;
         StRead:    state_in = (idx_ff < count_ff) ? StCompare : StRespond;
         StCompare: state_in = match ? StRespond : StRead;
         StRespond: if (rsp.ready) state_in = StIdle;
         default:   state_in = StIdle;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      rsp_in   = rsp_ff;
      wr_en    = 1'b0;
      case (state_ff)
         StIdle: begin
            if (req.valid) begin
               key_in = {req.data.pos_x, req.data.pos_y, req.data.pos_z,
                         req.data.pos_w, req.data.tex_u, req.data.tex_v,
                         req.data.tex_s, req.data.norm_x, req.data.norm_y,
                         req.data.norm_z};
               idx_in = '0;
               if (req.data.new_model) count_in = '0;
            end
         end
         StRead: begin
            if (idx_ff >= count_ff) begin
               if (count_ff >= CW'(TABLE_DEPTH)) begin
                  rsp_in.entry_index = '0;
                  rsp_in.outcome     = OutcomeFull;
               end else begin
                  wr_en              = 1'b1;
                  rsp_in.entry_index = IndexWidth'(count_ff);
                  rsp_in.outcome     = OutcomeInserted;
                  count_in           = count_ff + 1'b1;
               end
            end
         end
         StCompare: begin
            if (match) begin
               rsp_in.entry_index = IndexWidth'(idx_ff);
               rsp_in.outcome     = OutcomeFound;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   assign req.ready = (state_ff == StIdle);
   assign rsp.valid = (state_ff == StRespond);
   assign rsp.data  = rsp_ff;
endmodule
`default_nettype wire

[src/vkdt_key_ram.sv]
// ----------------------------------------------------------------------------
// vkdt_key_ram
// key storage, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module vkdt_key_ram #(
   parameter int unsigned DEPTH = vkdt_pkg::TableDepthDefault
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  wire logic [vkdt_pkg::KeyWidth-1:0]     wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]          rd_addr,
   output      logic [vkdt_pkg::KeyWidth-1:0]     rd_data
);
   import vkdt_pkg::*;
   logic [KeyWidth-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[test/tb_vertex_key_dedup_table_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vertex_key_dedup_table_core
// random and directed test of the vertex key find-or-insert table
// ----------------------------------------------------------------------------
// requests are sent through the request interface and mirrored into a local
// key table; every response is compared with the oldest predicted lookup.
// keys are drawn from small pools so that hits, repeats, signed zeros and
// nans all occur.
// ----------------------------------------------------------------------------
module tb_vertex_key_dedup_table_core;
   import vkdt_pkg::*;

   localparam int unsigned Depth = TableDepthDefault;
   localparam int unsigned CycleLimit = 8_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vkdt_req_if req_ch ();
   vkdt_rsp_if rsp_ch ();

   vertex_key_dedup_table_core #(.TABLE_DEPTH(Depth)) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // local copy of the table
   logic [31:0] mirror_keys [Depth][KeyWords];
   int unsigned mirror_count;
   rsp_type     pending_lookups [$];
   int unsigned error_count;
   int unsigned rsp_seen;
   int unsigned cycle_count;
   bit          sender_idle_on;
   bit          receiver_idle_on;
   int unsigned hold_off_cycles;
   int unsigned rx_idle_left;
   logic [31:0] key_pool [16][KeyWords];

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
   end

   function automatic logic [31:0] word_of(input req_type r, input int k);
      logic [31:0] w;
      case (k)
         0: w = r.pos_x;
         1: w = r.pos_y;
         2: w = r.pos_z;
         3: w = r.pos_w;
         4: w = r.tex_u;
         5: w = r.tex_v;
         6: w = r.tex_s;
         7: w = r.norm_x;
         8: w = r.norm_y;
         default: w = r.norm_z;
      endcase
      return w;
   endfunction

   function automatic bit float_same(input logic [31:0] a, input logic [31:0] b);
      bit a_nan;
      bit b_nan;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
      if (a_nan || b_nan) return 1'b0;
      if (a[30:0] == 0 && b[30:0] == 0) return 1'b1;
      return a == b;
   endfunction

   function automatic rsp_type predict_lookup(input req_type r);
      rsp_type res;
      bit      hit;
      if (r.new_model) mirror_count = 0;
      for (int unsigned i = 0; i < mirror_count; i++) begin
         hit = 1'b1;
         for (int k = 0; k < KeyWords; k++)
            if (!float_same(mirror_keys[i][k], word_of(r, k))) hit = 1'b0;
         if (hit) begin
            res.entry_index = i[IndexWidth-1:0];
            res.outcome     = OutcomeFound;
            return res;
         end
      end
      if (mirror_count >= Depth) begin
         res.entry_index = '0;
         res.outcome     = OutcomeFull;
         return res;
      end
      for (int k = 0; k < KeyWords; k++) mirror_keys[mirror_count][k] = word_of(r, k);
      res.entry_index = mirror_count[IndexWidth-1:0];
      res.outcome     = OutcomeInserted;
      mirror_count++;
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // valid stays high after a handshake unless an idle gap follows
   task automatic send_request(input req_type r);
      int unsigned gap;
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_lookups.push_back(predict_lookup(r));
   endtask

   function automatic req_type make_key(input bit nm, input logic [31:0] w [KeyWords]);
      req_type r;
      r.new_model = nm;
      r.pos_x = w[0]; r.pos_y = w[1]; r.pos_z = w[2]; r.pos_w = w[3];
      r.tex_u = w[4]; r.tex_v = w[5]; r.tex_s = w[6];
      r.norm_x = w[7]; r.norm_y = w[8]; r.norm_z = w[9];
      return r;
   endfunction

   function automatic logic [31:0] pick_component();
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0: v = 32'h0000_0000;
         1: v = 32'h8000_0000;
         2: v = 32'h7FC0_0000;
         3: v = 32'hFFFF_FFFF;
         4: v = 32'h3F80_0000;
         default: v = $urandom();
      endcase
      return v;
   endfunction

   // long hold-off countdown
   always @(posedge clock) begin
      if (hold_off_cycles != 0) hold_off_cycles <= hold_off_cycles - 1;
   end

   // receiver: random idle bursts plus one long hold-off
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rx_idle_left <= 0;
      end else if (hold_off_cycles != 0) begin
         rsp_ch.ready <= 1'b0;
      end else if (rx_idle_left != 0) begin
         rx_idle_left <= rx_idle_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
         rx_idle_left <= $urandom_range(0, 9);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_seen++;
         if (pending_lookups.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            exp_rsp = pending_lookups.pop_front();
            if (rsp_ch.data.entry_index !== exp_rsp.entry_index)
               report_mismatch($sformatf("entry_index %0d, expected %0d",
                  rsp_ch.data.entry_index, exp_rsp.entry_index));
            if (rsp_ch.data.outcome !== exp_rsp.outcome)
               report_mismatch($sformatf("outcome %0d, expected %0d",
                  rsp_ch.data.outcome, exp_rsp.outcome));
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL vertex_key_dedup_table_core");
         $finish;
      end
   end

   task automatic test_directed();
      logic [31:0] w [KeyWords];
      for (int k = 0; k < KeyWords; k++) w[k] = 32'h0000_0000;
      send_request(make_key(1'b1, w));
      send_request(make_key(1'b0, w));
      // negative zero matches positive zero
      for (int k = 0; k < KeyWords; k++) w[k] = 32'h8000_0000;
      send_request(make_key(1'b0, w));
      for (int k = 0; k < KeyWords; k++) w[k] = 32'hFFFF_FFFF;
      send_request(make_key(1'b0, w));
      send_request(make_key(1'b0, w));
      // nan never matches, even itself
      for (int k = 0; k < KeyWords; k++) w[k] = 32'h3F80_0000;
      w[4] = 32'h7FC0_0000;
      send_request(make_key(1'b0, w));
      send_request(make_key(1'b0, w));
      // infinity does match
      for (int k = 0; k < KeyWords; k++) w[k] = 32'h7F80_0000;
      send_request(make_key(1'b0, w));
      send_request(make_key(1'b0, w));
      // one component differs
      for (int k = 0; k < KeyWords; k++) w[k] = 32'h0000_0000;
      w[9] = 32'h0000_0001;
      send_request(make_key(1'b0, w));
      for (int k = 0; k < KeyWords; k++) w[k] = 32'h0000_0000;
      send_request(make_key(1'b1, w));
   endtask

   task automatic test_random_lookups(input int unsigned n);
      logic [31:0] w [KeyWords];
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 2) != 0) w = key_pool[$urandom_range(0, 15)];
         else for (int k = 0; k < KeyWords; k++) w[k] = pick_component();
         send_request(make_key($urandom_range(0, 60) == 0, w));
      end
   endtask

   task automatic test_backpressure();
      logic [31:0] w [KeyWords];
      hold_off_cycles <= 300;
      for (int i = 0; i < 6; i++) begin
         for (int k = 0; k < KeyWords; k++) w[k] = $urandom();
         send_request(make_key(1'b0, w));
      end
   endtask

   initial begin
      error_count = 0;
      rsp_seen = 0;
      cycle_count = 0;
      hold_off_cycles = 0;
      mirror_count = 0;
      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;
      for (int p = 0; p < 16; p++)
         for (int k = 0; k < KeyWords; k++) key_pool[p][k] = pick_component();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_lookups(400);
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      test_random_lookups(150);
      req_ch.valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (2 * Depth + 20) @(posedge clock);
      $display("covered %0d responses: zero signs, nans, infinities, repeats,", rsp_seen);
      $display("model restarts and a long receiver stall");
      if (error_count == 0) begin
         $display("PASS vertex_key_dedup_table_core");
      end else begin
         $display("%0d mismatches", error_count);
         $display("FAIL vertex_key_dedup_table_core");
      end
      $finish;
   end
endmodule

[vertex_key_dedup_table_core.f]
src/vkdt_pkg.sv
src/vkdt_req_if.sv
src/vkdt_rsp_if.sv
src/vkdt_key_ram.sv
src/vertex_key_dedup_table_core.sv
test/tb_vertex_key_dedup_table_core.sv
